/* hdl/msf_pkg.sv */
// ----------------------------------------------------------------------------
// msf_pkg
// Shared constants and types for the maximal square finder.
// ----------------------------------------------------------------------------
package msf_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CFG_W  = 11;
	localparam int SIDE_W = 11;
	localparam int AREA_W = 21;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

	// position flags of one pixel word, decided when the word is accepted
	typedef struct packed {
		logic pixel;
		logic last;
		logic first_row;
		logic wrap;
	} msf_pos_t;

endpackage

/* hdl/maximal_square_finder_core.sv */
// ----------------------------------------------------------------------------
// maximal_square_finder_core
// Largest all-ones square in a raster-order binary image stream.
//
//   channel  signals                       direction  word
//   in       in_valid/in_ready             sink       pixel, frame_end
//   out      out_valid/out_ready           source     square_side, square_area
//   cfg      cfg_we/cfg_data               sink       image_width
//
// One pixel word per cycle while the input is not stalled; a word first issues the
// line buffer read, then computes its side in stage 1 and writes it back.
// A write and a read of the same column in the same cycle (one-pixel rows) are
// served by forwarding the value just written.
// Reset clears the frame state at once; the line buffer needs no clearing.
// Input stalls only while a result waits in the output register and the frame
// end word behind it has nowhere to go.
// ----------------------------------------------------------------------------
module maximal_square_finder_core
	import msf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              pixel,
	input  logic              frame_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SIDE_W-1:0] square_side,
	output logic [AREA_W-1:0] square_area,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SW = $clog2(MAX_WIDTH + 1);

	logic [CFG_W-1:0] width_q;
	logic             accept;
	logic [CW-1:0]    rd_col;
	msf_pos_t         pos;
	logic [SW-1:0]    rd_data;

	logic             s1_valid_q;
	logic [CW-1:0]    col_s1;
	msf_pos_t         pos_s1;
	logic             fwd_s1;
	logic             s1_adv;

	logic [SW-1:0]    prev_side_q;
	logic [SW-1:0]    left_q;
	logic [SW-1:0]    ul_q;
	logic [SW-1:0]    best_q;

	logic [SW-1:0]    above;
	logic [SW-1:0]    min3;
	logic [SW-1:0]    side_new;
	logic [SW-1:0]    best_new;

	logic             out_valid_q;
	logic [SW-1:0]    out_side_q;
	logic [2*SW-1:0]  sq;
	logic [31:0]      side_ext;
	logic [31:0]      sq_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	// a frame end word may leave stage 1 only into a free output slot
	assign s1_adv   = !(pos_s1.last && out_valid_q && !out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	msf_col_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.SW        (SW)
	) u_col_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.pixel       (pixel),
		.frame_end   (frame_end),
		.image_width (width_q),
		.col         (rd_col),
		.pos         (pos)
	);

	msf_line_ram #(
		.DEPTH (MAX_WIDTH),
		.DW    (SW),
		.AW    (CW)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_col),
		.rd_data (rd_data),
		.wr_en   (s1_valid_q && s1_adv),
		.wr_addr (col_s1),
		.wr_data (side_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= rd_col;
			pos_s1 <= pos;
			// read and write of the same column at this edge: read sees old data
			fwd_s1 <= s1_valid_q && (col_s1 == rd_col);
		end
	end

	always_comb begin
		if (pos_s1.first_row) begin
			above = '0;
		end else if (fwd_s1) begin
			above = prev_side_q;
		end else begin
			above = rd_data;
		end
	end

	always_comb begin
		min3 = left_q;
		if (above < min3) begin
			min3 = above;
		end
		if (ul_q < min3) begin
			min3 = ul_q;
		end
	end

	always_comb begin
		if (!pos_s1.pixel) begin
			side_new = '0;
		end else if (pos_s1.first_row || col_s1 == '0) begin
			side_new = SW'(1);
		end else begin
			side_new = min3 + SW'(1);
		end
	end

	assign best_new = (side_new > best_q) ? side_new : best_q;

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			prev_side_q <= side_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ul_q   <= '0;
			best_q <= '0;
		end else if (s1_valid_q && s1_adv) begin
			if (pos_s1.last || pos_s1.wrap) begin
				left_q <= '0;
				ul_q   <= '0;
			end else begin
				left_q <= side_new;
				ul_q   <= above;
			end
			best_q <= pos_s1.last ? '0 : best_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv && pos_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv && pos_s1.last) begin
			out_side_q <= best_new;
		end
	end

	assign sq       = out_side_q * out_side_q;
	assign side_ext = 32'(out_side_q);
	assign sq_ext   = 32'(sq);

	assign out_valid   = out_valid_q;
	assign square_side = side_ext[SIDE_W-1:0];
	assign square_area = sq_ext[AREA_W-1:0];

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> rd_col == '0 && pos.first_row)
		else $error("column state not cleared after frame end");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_adv && pos_s1.last |=> best_q == '0)
		else $error("best side not cleared after result");

	a_side_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> side_new <= SW'(col_s1) + SW'(1))
		else $error("side exceeds column count");

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s1_valid_q && col_s1 == rd_col |=> fwd_s1 && s1_valid_q)
		else $error("forwarding not armed for same-column access");

endmodule

/* hdl/msf_line_ram.sv */
// ----------------------------------------------------------------------------
// msf_line_ram
// One-port-write, one-port-read line buffer with registered read data.
// ----------------------------------------------------------------------------
module msf_line_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 11,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/msf_col_ctrl.sv */
// ----------------------------------------------------------------------------
// msf_col_ctrl
// Column counter and first-row flag; flags each accepted pixel word.
// ----------------------------------------------------------------------------
module msf_col_ctrl
	import msf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int CW        = 10,
	parameter int SW        = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             pixel,
	input  logic             frame_end,
	input  logic [CFG_W-1:0] image_width,
	output logic [CW-1:0]    col,
	output msf_pos_t         pos
);

	logic [CW-1:0] col_q;
	logic          first_row_q;
	logic [SW-1:0] act_w;
	logic [SW-1:0] col_inc;

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (image_width == '0) begin
			act_w = SW'(1);
		end else if (32'(image_width) > MAX_WIDTH) begin
			act_w = SW'(MAX_WIDTH);
		end else begin
			act_w = SW'(image_width);
		end
	end

	assign col_inc = SW'(col_q) + SW'(1);

	assign col           = col_q;
	assign pos.pixel     = pixel;
	assign pos.last      = frame_end;
	assign pos.first_row = first_row_q;
	assign pos.wrap      = (col_inc >= act_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (advance) begin
			if (frame_end) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
			end else if (pos.wrap) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

/* tb/tb_maximal_square_finder_core.sv */
// ----------------------------------------------------------------------------
// tb_maximal_square_finder_core
// Self-checking bench for the streaming maximal square finder.
//
// A line-buffer predictor tracks every accepted pixel word and queues the side
// and area due on each frame end. Results are compared in order as they leave
// the block. Stimulus starts from a short hand-written table, then runs random
// frames over a range of row widths (0 and above the line size included),
// with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_maximal_square_finder_core;
	import msf_pkg::*;

	localparam int LINE_MAX    = MAX_WIDTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS    = 29;

	typedef struct packed {
		logic [SIDE_W-1:0] side;
		logic [AREA_W-1:0] area;
	} square_t;

	typedef enum logic {ROW_PIXEL, ROW_WIDTH} dir_kind_t;

	typedef struct packed {
		dir_kind_t         kind;
		logic              pix;
		logic              last;
		logic              typed;
		logic [SIDE_W-1:0] side;
		logic [AREA_W-1:0] area;
		logic [CFG_W-1:0]  width;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              pixel;
	logic              frame_end;
	logic              out_valid;
	logic              out_ready;
	logic [SIDE_W-1:0] square_side;
	logic [AREA_W-1:0] square_area;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_data;

	// hand-typed result riding along with the current word
	logic              typed_now;
	logic [SIDE_W-1:0] typed_side;
	logic [AREA_W-1:0] typed_area;

	// line-buffer predictor state
	logic [SIDE_W-1:0] line_sides [LINE_MAX];
	logic [SIDE_W-1:0] left_s;
	logic [SIDE_W-1:0] upleft_s;
	logic [SIDE_W-1:0] best_s;
	int unsigned       col_pos;
	logic              top_row;
	logic [CFG_W-1:0]  width_cfg;

	square_t     pending_squares [$];
	int unsigned err_count;
	int unsigned idle_cycles;
	bit          tx_calm;
	bit          rx_calm;
	bit          hold_req;

	dir_row_t dir_tab [DIR_ROWS];

	maximal_square_finder_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.square_side (square_side),
		.square_area (square_area),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned width_of(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > LINE_MAX)
			return LINE_MAX;
		return v;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic dir_row_t row_px(input logic pix, input logic last);
		return '{ROW_PIXEL, pix, last, 1'b0, '0, '0, '0};
	endfunction

	function automatic dir_row_t row_sq(input logic pix, input logic last,
			input logic [SIDE_W-1:0] side, input logic [AREA_W-1:0] area);
		return '{ROW_PIXEL, pix, last, 1'b1, side, area, '0};
	endfunction

	function automatic dir_row_t row_w(input logic [CFG_W-1:0] v);
		return '{ROW_WIDTH, 1'b0, 1'b0, 1'b0, '0, '0, v};
	endfunction

	task automatic clear_square_frame();
		left_s   = '0;
		upleft_s = '0;
		best_s   = '0;
		col_pos  = 0;
		top_row  = 1'b1;
	endtask

	// append one expected square at the tail
	task automatic queue_square(input square_t sq_in);
		pending_squares = {pending_squares, sq_in};
	endtask

	// One pixel through the dynamic-programming recurrence.
	task automatic step_square(input logic pix, input logic last,
			output logic emit, output square_t res);
		int unsigned       w;
		int unsigned       c;
		logic [SIDE_W-1:0] above;
		logic [SIDE_W-1:0] m;
		logic [SIDE_W-1:0] s;
		logic [31:0]       sq;
		w     = width_of(width_cfg);
		c     = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
		above = top_row ? '0 : line_sides[c];
		if (!pix) begin
			s = '0;
		end else if (top_row || c == 0) begin
			s = SIDE_W'(1);
		end else begin
			m = left_s;
			if (above < m)
				m = above;
			if (upleft_s < m)
				m = upleft_s;
			s = m + 1'b1;
		end
		line_sides[c] = s;
		if (s > best_s)
			best_s = s;
		if (c + 1 >= w) begin
			col_pos  = 0;
			top_row  = 1'b0;
			left_s   = '0;
			upleft_s = '0;
		end else begin
			col_pos  = c + 1;
			left_s   = s;
			upleft_s = above;
		end
		emit = last;
		res  = '0;
		if (last) begin
			sq       = {21'd0, best_s} * {21'd0, best_s};
			res.side = best_s;
			res.area = sq[AREA_W-1:0];
			clear_square_frame();
		end
	endtask

	// Check leaving squares first, then predict for the word going in.
	always @(posedge clk) begin : check
		logic    emit;
		square_t res;
		square_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_squares.size() == 0) begin
					$display("%0t: unexpected square side %0d area %0d",
						$time, square_side, square_area);
					err_count++;
				end else begin
					want = pending_squares.pop_front();
					if (square_side !== want.side) begin
						$display("%0t: square_side expected %0d got %0d",
							$time, want.side, square_side);
						err_count++;
					end
					if (square_area !== want.area) begin
						$display("%0t: square_area expected %0d got %0d",
							$time, want.area, square_area);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				step_square(pixel, frame_end, emit, res);
				if (emit) begin
					if (typed_now) begin
						res.side = typed_side;
						res.area = typed_area;
					end
					queue_square(res);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_word(input logic pix, input logic last, input logic typed,
			input logic [SIDE_W-1:0] ts, input logic [AREA_W-1:0] ta);
		int unsigned gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		pixel      <= pix;
		frame_end  <= last;
		typed_now  <= typed;
		typed_side <= ts;
		typed_area <= ta;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Write only with the block drained and the pipeline given time to settle.
	task automatic set_width(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_squares.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_data  <= v;
		width_cfg  = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned n_pix, input int unsigned dens);
		for (int unsigned i = 0; i < n_pix; i++)
			send_word($urandom_range(0, 99) < dens, i == n_pix - 1, 1'b0, '0, '0);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] wval, input int unsigned quota,
			input int unsigned max_rows);
		int unsigned w;
		int unsigned sent;
		int unsigned sel;
		int unsigned dens;
		int unsigned n;
		set_width(wval);
		w       = width_of(wval);
		sent    = 0;
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		while (sent < quota) begin
			sel = $urandom_range(0, 9);
			case ($urandom_range(0, 2))
				0: dens = 50;
				1: dens = 85;
				default: dens = 97;
			endcase
			if (w > 64) begin
				// wide rows: keep frames inside the first row
				n = $urandom_range(1, 48);
			end else if (sel <= 6) begin
				n = w * $urandom_range(1, max_rows);
			end else if (sel == 7) begin
				n = $urandom_range(1, w * max_rows);
			end else if (sel == 8) begin
				n    = w * $urandom_range(1, max_rows);
				dens = 50;
			end else begin
				n = 1;
			end
			send_frame(n, dens);
			sent += n;
		end
	endtask

	initial begin : rx
		int unsigned stall_left;
		logic        nxt;
		out_ready  <= 1'b0;
		stall_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b0;
			end else begin
				nxt        = 1'b1;
				stall_left = rx_calm ? 0 : pick_gap();
			end
			out_ready <= nxt;
		end
	end

	initial begin : tx
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		pixel      <= 1'b0;
		frame_end  <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_data   <= '0;
		typed_now  <= 1'b0;
		typed_side <= '0;
		typed_area <= '0;
		err_count   = 0;
		idle_cycles = 0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		hold_req    = 1'b0;
		width_cfg   = WIDTH_RESET;
		foreach (line_sides[i])
			line_sides[i] = '0;
		clear_square_frame();

		dir_tab = '{
			row_sq(1'b0, 1'b1, 11'd0, 21'd0),
			row_sq(1'b1, 1'b1, 11'd1, 21'd1),
			// zero width acts as one-pixel rows: every pixel is first column
			row_w(11'd0),
			row_px(1'b1, 1'b0), row_px(1'b1, 1'b0), row_px(1'b1, 1'b0),
			row_sq(1'b1, 1'b1, 11'd1, 21'd1),
			row_w(11'd2),
			row_px(1'b1, 1'b0), row_px(1'b1, 1'b0), row_px(1'b1, 1'b0),
			row_sq(1'b1, 1'b1, 11'd2, 21'd4),
			row_w(11'd3),
			row_px(1'b1, 1'b0), row_px(1'b1, 1'b0), row_px(1'b1, 1'b0),
			row_px(1'b1, 1'b0), row_px(1'b1, 1'b0), row_px(1'b1, 1'b0),
			row_px(1'b1, 1'b0), row_px(1'b1, 1'b0),
			row_sq(1'b1, 1'b1, 11'd3, 21'd9),
			// frame end on the first column of the second row
			row_px(1'b1, 1'b0), row_px(1'b0, 1'b0), row_px(1'b1, 1'b0),
			row_px(1'b1, 1'b1),
			// width above the line size clamps to the line size
			row_w(11'd2047),
			row_px(1'b0, 1'b0), row_px(1'b1, 1'b1)
		};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_WIDTH)
				set_width(dir_tab[i].width);
			else
				send_word(dir_tab[i].pix, dir_tab[i].last, dir_tab[i].typed,
					dir_tab[i].side, dir_tab[i].area);
		end

		run_phase(11'd1, 30, 6);
		run_phase(11'd2, 40, 6);
		run_phase(11'd3, 40, 6);
		run_phase(11'd4, 40, 6);
		run_phase(11'd7, 40, 5);
		run_phase(CFG_W'($urandom_range(5, 16)), 40, 4);
		run_phase(11'd0, 20, 8);
		run_phase(11'd1024, 30, 1);
		run_phase(11'd2047, 20, 1);
		run_phase(CFG_W'($urandom_range(1, 12)), 40, 5);

		// hold the output while single-pixel frames pile up behind it
		set_width(11'd1);
		tx_calm  = 1'b1;
		rx_calm  = 1'b0;
		hold_req = 1'b1;
		repeat (40) send_frame(1, 50);

		run_phase(CFG_W'($urandom_range(1, 16)), 40, 5);

		in_valid <= 1'b0;
		while (pending_squares.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_squares.size() != 0) begin
			$display("%0t: %0d squares never arrived", $time, pending_squares.size());
			err_count++;
		end
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
hdl/msf_pkg.sv
hdl/msf_line_ram.sv
hdl/msf_col_ctrl.sv
hdl/maximal_square_finder_core.sv
tb/tb_maximal_square_finder_core.sv
